// ===== hw/rtl/lru_pfr_pkg.sv =====
`default_nettype none

package lru_pfr_pkg;

  localparam int MAX_FRAMES = 128;
  localparam int FRAME_BITS = $clog2(MAX_FRAMES);
  localparam int AGE_BITS = 16;
  localparam int PAGE_BITS = 31;
  localparam int CFG_BITS = 8;
  localparam int IDX_OUT_BITS = 7;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
  localparam logic [FRAME_BITS-1:0] LAST_FRAME = FRAME_BITS'(MAX_FRAMES - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lru_page_frame_replacer_unit.sv =====
// A reference is handled as one read per frame in use, then the registered read data of the tag and
//   age memories, then a writeback that also loads the result (it waits while a result is still held).
// No new reference is taken until the current one has been written back, after the single pass over
//   the tag and age memories through their one read port.
// Reset: synchronous, active high; all frames empty, frames_in_use at 128, no result held.
//   A write to frames_in_use empties the table through the valid flops.
`default_nettype none

module lru_page_frame_replacer_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [7:0]  cfg_wdata,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [30:0] page_number
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] miss, [7:1] frame_index
);

  localparam int FB = lru_pfr_pkg::FRAME_BITS;
  localparam int AB = lru_pfr_pkg::AGE_BITS;
  localparam int PB = lru_pfr_pkg::PAGE_BITS;

  logic [PB-1:0] tag_mem [lru_pfr_pkg::MAX_FRAMES];
  logic [AB-1:0] age_mem [lru_pfr_pkg::MAX_FRAMES];

  lru_pfr_pkg::state_t state;
  logic [lru_pfr_pkg::MAX_FRAMES-1:0] valid;
  logic [FB-1:0] last_frame;
  logic [PB-1:0] page;

  logic          issuing;
  logic [FB-1:0] rd_addr;
  logic          rd_vld;
  logic [FB-1:0] rd_idx;
  logic [PB-1:0] tag_q;
  logic [AB-1:0] age_q;

  logic          hit;
  logic [FB-1:0] hit_idx;
  logic [FB-1:0] victim;
  logic [AB-1:0] best;

  logic          cur_valid;
  logic [AB-1:0] cur_age;
  logic [AB-1:0] aged;
  logic          cur_hit;
  logic          take;
  logic          done_write;
  logic [FB-1:0] sel;

  logic          age_we;
  logic [FB-1:0] age_waddr;
  logic [AB-1:0] age_wdata;

  assign s_axis_tready = (state == lru_pfr_pkg::S_IDLE);

  always_comb begin
    cur_valid = valid[rd_idx];
    cur_age   = cur_valid ? age_q : lru_pfr_pkg::AGE_MAX;
    aged      = (cur_age == lru_pfr_pkg::AGE_MAX) ? cur_age : cur_age + AB'(1);
    cur_hit   = cur_valid && (tag_q == page);
    take      = (rd_idx == '0) || (aged > best);
    sel       = hit ? hit_idx : victim;
    done_write = (state == lru_pfr_pkg::S_WRITE) && (!m_axis_tvalid || m_axis_tready);
    if (done_write) begin
      age_we    = 1'b1;
      age_waddr = sel;
      age_wdata = '0;
    end else begin
      age_we    = (state == lru_pfr_pkg::S_SCAN) && rd_vld;
      age_waddr = rd_idx;
      age_wdata = aged;
    end
  end

  always_ff @(posedge clk) begin
    tag_q <= tag_mem[rd_addr];
    age_q <= age_mem[rd_addr];
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    if (done_write && !hit) begin
      tag_mem[sel] <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lru_pfr_pkg::S_IDLE;
      valid         <= '0;
      last_frame    <= lru_pfr_pkg::LAST_FRAME;
      issuing       <= 1'b0;
      rd_vld        <= 1'b0;
      rd_addr       <= '0;
      hit           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        valid <= '0;
        if (cfg_wdata == '0) begin
          last_frame <= '0;
        end else if (cfg_wdata > lru_pfr_pkg::CFG_BITS'(lru_pfr_pkg::MAX_FRAMES)) begin
          last_frame <= lru_pfr_pkg::LAST_FRAME;
        end else begin
          last_frame <= FB'(cfg_wdata - lru_pfr_pkg::CFG_BITS'(1));
        end
      end
      unique case (state)
        lru_pfr_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            page    <= s_axis_tdata[PB-1:0];
            issuing <= 1'b1;
            rd_addr <= '0;
            rd_vld  <= 1'b0;
            hit     <= 1'b0;
            state   <= lru_pfr_pkg::S_SCAN;
          end
        end
        lru_pfr_pkg::S_SCAN: begin
          rd_vld <= issuing;
          rd_idx <= rd_addr;
          if (issuing) begin
            if (rd_addr == last_frame) begin
              issuing <= 1'b0;
            end else begin
              rd_addr <= rd_addr + FB'(1);
            end
          end
          if (rd_vld) begin
            if (!hit && cur_hit) begin
              hit     <= 1'b1;
              hit_idx <= rd_idx;
            end
            if (take) begin
              best   <= aged;
              victim <= rd_idx;
            end
            if (rd_idx == last_frame) begin
              rd_vld <= 1'b0;
              state  <= lru_pfr_pkg::S_WRITE;
            end
          end
        end
        lru_pfr_pkg::S_WRITE: begin
          if (done_write) begin
            valid[sel]    <= 1'b1;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {lru_pfr_pkg::IDX_OUT_BITS'(sel), !hit};
            rd_addr       <= '0;
            state         <= lru_pfr_pkg::S_IDLE;
          end
        end
        default: begin
          state <= lru_pfr_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_lru_page_frame_replacer_unit.sv =====
`timescale 1ns / 1ps

module tb_lru_page_frame_replacer_unit;

  typedef struct packed {
    logic [lru_pfr_pkg::IDX_OUT_BITS-1:0] frame_index;
    logic                                 miss;
  } placement_t;

  class frame_table_scoreboard;
    logic [lru_pfr_pkg::PAGE_BITS-1:0] tag [lru_pfr_pkg::MAX_FRAMES];
    bit                                valid [lru_pfr_pkg::MAX_FRAMES];
    logic [lru_pfr_pkg::AGE_BITS-1:0]  age [lru_pfr_pkg::MAX_FRAMES];
    logic [lru_pfr_pkg::CFG_BITS-1:0]  frames_cfg;
    placement_t                        placements_q[$];
    int                                errors;

    function new();
      frames_cfg = lru_pfr_pkg::CFG_BITS'(lru_pfr_pkg::MAX_FRAMES);
      errors = 0;
      empty_table();
    endfunction

    function void empty_table();
      int i;
      for (i = 0; i < lru_pfr_pkg::MAX_FRAMES; i++) begin
        tag[i] = '0;
        valid[i] = 1'b0;
        age[i] = lru_pfr_pkg::AGE_MAX;
      end
    endfunction

    function void set_frames(input logic [lru_pfr_pkg::CFG_BITS-1:0] v);
      frames_cfg = v;
      empty_table();
    endfunction

    function int pending();
      return placements_q.size();
    endfunction

    function void note_reference(input logic [lru_pfr_pkg::PAGE_BITS-1:0] pg);
      int i;
      int n;
      int victim;
      bit hit;
      logic [lru_pfr_pkg::AGE_BITS-1:0] best;
      logic [lru_pfr_pkg::AGE_BITS-1:0] a;
      placement_t p;
      n = (frames_cfg == 0) ? 1 :
          ((frames_cfg > lru_pfr_pkg::MAX_FRAMES) ? lru_pfr_pkg::MAX_FRAMES : int'(frames_cfg));
      for (i = 0; i < n; i++)
        if (age[i] != lru_pfr_pkg::AGE_MAX) age[i] = age[i] + 1'b1;
      hit = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!hit && valid[i] && tag[i] == pg) begin
          hit = 1'b1;
          age[i] = '0;
          p.miss = 1'b0;
          p.frame_index = lru_pfr_pkg::IDX_OUT_BITS'(i);
        end
      end
      if (!hit) begin
        victim = 0;
        best = '0;
        for (i = 0; i < n; i++) begin
          a = valid[i] ? age[i] : lru_pfr_pkg::AGE_MAX;
          if (i == 0 || a > best) begin
            best = a;
            victim = i;
          end
        end
        tag[victim] = pg;
        valid[victim] = 1'b1;
        age[victim] = '0;
        p.miss = 1'b1;
        p.frame_index = lru_pfr_pkg::IDX_OUT_BITS'(victim);
      end
      placements_q.push_back(p);
    endfunction

    function void check_result(input logic [7:0] data);
      placement_t exp_p;
      if (placements_q.size() == 0) begin
        $error("unexpected result: miss %0d frame_index %0d", data[0], data[7:1]);
        errors++;
        return;
      end
      exp_p = placements_q.pop_front();
      if (data[0] !== exp_p.miss) begin
        $error("miss: expected %0d, actual %0d", exp_p.miss, data[0]);
        errors++;
      end
      if (data[7:1] !== exp_p.frame_index) begin
        $error("frame_index: expected %0d, actual %0d", exp_p.frame_index, data[7:1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [30:0] page_number
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] miss, [7:1] frame_index

  frame_table_scoreboard tracker = new();
  bit quiet;
  bit hold_off_req;

  lru_page_frame_replacer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #48_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // hold off long enough for the block to fill and stall its input
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (600) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_page(input logic [lru_pfr_pkg::PAGE_BITS-1:0] pg);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pg};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_reference(pg);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic write_frames(input logic [lru_pfr_pkg::CFG_BITS-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tracker.set_frames(v);
  endtask

  task automatic run_phase(input logic [lru_pfr_pkg::CFG_BITS-1:0] v, input int count,
                           input int hold_at);
    logic [lru_pfr_pkg::PAGE_BITS-1:0] working_set[$];
    int active;
    int ws_size;
    int k;
    logic [lru_pfr_pkg::PAGE_BITS-1:0] pg;
    write_frames(v);
    active = (v == 0) ? 1 :
             ((v > lru_pfr_pkg::MAX_FRAMES) ? lru_pfr_pkg::MAX_FRAMES : int'(v));
    ws_size = active + $urandom_range(1, active / 2 + 2);
    for (k = 0; k < ws_size; k++) working_set.push_back(lru_pfr_pkg::PAGE_BITS'($urandom));
    for (k = 0; k < count; k++) begin
      if (k == hold_at) hold_off_req = 1'b1;
      if ($urandom_range(0, 4) == 0) pg = lru_pfr_pkg::PAGE_BITS'($urandom);
      else pg = working_set[$urandom_range(0, ws_size - 1)];
      sender_gap();
      send_page(pg);
    end
  endtask

  initial begin
    logic [lru_pfr_pkg::PAGE_BITS-1:0] pa, pb, pc;
    int k;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet         = 1'b0;
    hold_off_req  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset table, all frames in use
    send_page('0);
    send_page({lru_pfr_pkg::PAGE_BITS{1'b1}});
    send_page('0);
    send_page(31'h5555_5555);
    send_page(31'h2AAA_AAAA);
    send_page({lru_pfr_pkg::PAGE_BITS{1'b1}});

    // one frame: every new page replaces the only frame
    write_frames(8'd1);
    send_page(31'h0000_0011);
    send_page(31'h0000_0022);
    send_page(31'h0000_0022);
    // zero count acts as one frame
    write_frames(8'd0);
    send_page(31'h0000_0011);
    send_page(31'h0000_0011);
    send_page(31'h0000_0022);
    // count above capacity saturates
    write_frames(8'hFF);
    send_page(31'h0000_0033);
    send_page(31'h7000_0000);
    send_page(31'h0000_0033);
    // victim choice by age
    write_frames(8'd3);
    send_page(31'h0000_0101);
    send_page(31'h0000_0202);
    send_page(31'h0000_0303);
    send_page(31'h0000_0202);
    send_page(31'h0000_0404);
    send_page(31'h0000_0505);

    // two idle frames age while one stays hot; the oldest is replaced
    quiet = 1'b1;
    write_frames(8'd3);
    pa = lru_pfr_pkg::PAGE_BITS'($urandom);
    pb = pa ^ 31'h0000_0001;
    pc = pa ^ 31'h4000_0000;
    send_page(pa);
    send_page(pb);
    send_page(pc);
    for (k = 0; k < 20; k++) send_page(pc);
    send_page(pa ^ 31'h0000_0002);
    quiet = 1'b0;

    run_phase(8'd1, 60, -1);
    run_phase(8'd0, 60, -1);
    run_phase(8'd2, 80, -1);
    run_phase(8'd4, 120, 10);
    run_phase(8'd8, 120, -1);
    run_phase(8'd16, 150, -1);
    run_phase(8'd5, 100, -1);
    run_phase(8'hFF, 80, -1);
    run_phase(8'd128, 100, -1);
    run_phase(8'd129, 60, -1);
    run_phase(8'd200, 60, -1);
    run_phase(8'd127, 80, -1);
    run_phase(8'($urandom_range(1, 32)), 100, -1);
    quiet = 1'b1;
    run_phase(8'($urandom_range(1, 12)), 120, -1);

    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (140) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lru_pfr_pkg.sv
hw/rtl/lru_page_frame_replacer_unit.sv
verif/tb_lru_page_frame_replacer_unit.sv
